// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl of the grid vector codec
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define GVQ_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("%m: assertion failed");

// consequent must hold in the cycle after the antecedent
`define GVQ_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ----- hw/rtl/gvq_pkg.sv -----
// types, constants and conversion functions of the grid vector codec
// no dependencies
`timescale 1ns / 1ps

package gvq_pkg;

	localparam int CODE_BITS = 11;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} gvq_op_t;

	typedef struct packed {
		gvq_op_t     opcode;
		logic        grid_flag_in;
		logic [31:0] word_x;
		logic [31:0] word_y;
		logic [31:0] word_z;
	} gvq_cmd_t;

	typedef struct packed {
		logic        grid_flag_out;
		logic [31:0] result_x;
		logic [31:0] result_y;
		logic [31:0] result_z;
	} gvq_rsp_t;

	// smallest float bit pattern that is not below 204.8 in double
	localparam logic [31:0] Y_LIMIT_BITS = 32'h434C_CCCD;
	// 0.0005f with its lsb at 2^-50
	localparam logic [49:0] FRAC_TOL = 50'h0_0083_126F_0000;
	// (2^32 - 1) / 5, and 2^16 / 5 rounded up for small quotients
	localparam logic [40:0] FIFTH_Q32 = 41'h0_3333_3333;
	localparam logic [24:0] FIFTH_Q16 = 25'd13108;

	// half-step coordinate to code: {ok, code}
	function automatic logic [CODE_BITS:0] float_to_half(logic [31:0] w);
		logic [7:0]           e;
		logic [22:0]          m;
		logic [3:0]           sh;
		logic [22:0]          low;
		logic [23:0]          sig;
		logic [CODE_BITS-1:0] mag;
		logic [CODE_BITS-1:0] code;
		logic                 ok;
		e    = w[30:23];
		m    = w[22:0];
		sh   = 4'(e - 8'd126);
		low  = m << sh;
		sig  = {1'b1, m} >> (5'd23 - 5'(sh));
		mag  = {1'b0, sig[CODE_BITS-2:0]};
		code = w[31] ? (~mag + 1'b1) : mag;
		ok   = (e >= 8'd126) && (e <= 8'd135) && (low == '0);
		if (e == '0 && m == '0) begin
			ok   = 1'b1;
			code = '0;
		end
		return {ok, code};
	endfunction

	// tenth-step height to code: {ok, code}
	function automatic logic [CODE_BITS:0] float_to_tenth(logic [31:0] w);
		logic [7:0]           e;
		logic [23:0]          sig;
		logic [27:0]          p;
		logic [24:0]          d;
		logic [28:0]          q;
		logic [5:0]           sh;
		logic [62:0]          dfix;
		logic                 in_range;
		logic                 ok;
		logic [CODE_BITS-1:0] code;
		e   = w[30:23];
		sig = {1'b1, w[22:0]};
		p   = 28'(sig) * 28'd10;
		// round the product to single precision, nearest even
		if (p[27]) begin
			d = 25'(p[27:4]) + 25'(p[3] & ((|p[2:0]) | p[4]));
			q = {d, 4'b0};
		end else begin
			d = 25'(p[26:3]) + 25'(p[2] & ((|p[1:0]) | p[3]));
			q = {1'b0, d, 3'b0};
		end
		sh       = 6'(e - 8'd100);
		dfix     = 63'(q) << sh;
		in_range = w[31] ? (w[30:0] == '0) : (w < Y_LIMIT_BITS);
		if (!in_range) begin
			ok   = 1'b0;
			code = '0;
		end else if (e < 8'd100) begin
			// product far below the tolerance
			ok   = 1'b1;
			code = '0;
		end else begin
			ok   = (dfix[49:0] <= FRAC_TOL);
			code = dfix[50+CODE_BITS-1:50];
		end
		return {ok, code};
	endfunction

	// signed half-step code to float
	function automatic logic [31:0] half_to_float(logic [CODE_BITS-1:0] c);
		logic                 neg;
		logic [CODE_BITS-1:0] mag;
		logic [3:0]           q;
		logic [7:0]           ex;
		logic [23:0]          sh;
		neg = c[CODE_BITS-1];
		mag = neg ? (~c + 1'b1) : c;
		q   = '0;
		for (int i = 0; i < CODE_BITS; i++) begin
			if (mag[i]) q = 4'(i);
		end
		ex = 8'(q) + 8'd126;
		sh = 24'(mag) << (5'd23 - 5'(q));
		return (mag == '0) ? 32'h0 : {neg, ex, sh[22:0]};
	endfunction

	// unsigned tenth-step code to float, round to nearest even
	function automatic logic [31:0] tenth_to_float(logic [CODE_BITS-1:0] c);
		logic [24:0]          q5p;
		logic [8:0]           q5;
		logic [CODE_BITS-1:0] rem;
		logic [40:0]          v;
		logic [5:0]           p;
		logic [40:0]          n;
		logic [7:0]           ex;
		logic                 st;
		logic                 rnd;
		logic [31:0]          base;
		q5p  = 25'(c) * FIFTH_Q16;
		q5   = q5p[24:16];
		rem  = c - {q5, 2'b0} - {2'b0, q5};
		// c * 2^32 / 5, truncated
		v    = 41'(c) * FIFTH_Q32 + 41'(q5);
		p    = '0;
		for (int i = 0; i < 41; i++) begin
			if (v[i]) p = 6'(i);
		end
		n    = v << (6'd40 - p);
		ex   = 8'(p) + 8'd94;
		st   = (|n[15:0]) | (|rem);
		rnd  = n[16] & (st | n[17]);
		base = {1'b0, ex, n[39:17]};
		return (c == '0) ? 32'h0 : base + 32'(rnd);
	endfunction

endpackage

// ----- hw/rtl/gvq_conv.sv -----
// combinational encode and decode of one vector word
// depends on gvq_pkg
`timescale 1ns / 1ps

module gvq_conv import gvq_pkg::*; (
	input  gvq_cmd_t cmd,
	output gvq_rsp_t rsp
);

	logic [CODE_BITS:0] hx, hz, ty;
	logic               on_grid;

	// per-axis grid tests
	assign hx      = float_to_half(cmd.word_x);
	assign hz      = float_to_half(cmd.word_z);
	assign ty      = float_to_tenth(cmd.word_y);
	assign on_grid = hx[CODE_BITS] & hz[CODE_BITS] & ty[CODE_BITS];

	// result selection
	always_comb begin
		rsp.grid_flag_out = 1'b0;
		rsp.result_x      = cmd.word_x;
		rsp.result_y      = cmd.word_y;
		rsp.result_z      = cmd.word_z;
		case (cmd.opcode)
			OP_ENCODE: begin
				if (on_grid) begin
					rsp.grid_flag_out = 1'b1;
					rsp.result_x      = 32'(hx[CODE_BITS-1:0]);
					rsp.result_y      = 32'(ty[CODE_BITS-1:0]);
					rsp.result_z      = 32'(hz[CODE_BITS-1:0]);
				end
			end
			OP_DECODE: begin
				rsp.grid_flag_out = cmd.grid_flag_in;
				if (cmd.grid_flag_in) begin
					rsp.result_x = half_to_float(cmd.word_x[CODE_BITS-1:0]);
					rsp.result_y = tenth_to_float(cmd.word_y[CODE_BITS-1:0]);
					rsp.result_z = half_to_float(cmd.word_z[CODE_BITS-1:0]);
				end
			end
			default: begin
				rsp.grid_flag_out = 1'b0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/grid_vector_quantize_codec_unit.sv -----
// Grid vector codec: packs three float coordinates into grid codes or back.
//
// Command channel: cmd is taken at a rising edge with start high and busy
// low. busy is always low, so a word can be issued every cycle.
// Result channel: rsp is valid for exactly one cycle while done is high.
// There is no backpressure; the receiver must take each word as it comes.
// The command is registered at acceptance, converted in the next
// cycle and registered again together with done. Throughput is one
// word per cycle, set by a single conversion stage between the input
// and result registers.
// Encode yields flag 1 and three codes for an on-grid point, else flag 0
// with the words unchanged. Decode with flag 1 rebuilds the floats, with
// flag 0 it passes the words through.
// Reset clears the stage valid bits; words in flight are dropped and no
// done pulse follows reset until a new command is accepted.
// depends on gvq_pkg, gvq_conv and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module grid_vector_quantize_codec_unit import gvq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  gvq_cmd_t cmd,
	output logic     done,
	output gvq_rsp_t rsp
);

	logic     valid_s1;
	gvq_cmd_t cmd_s1;
	gvq_rsp_t rsp_d;
	gvq_rsp_t rsp_q;
	logic     done_q;
	logic     enc_on_grid;
	logic     rsp_hi_clear;

	assign busy = 1'b0;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	// conversion
	gvq_conv u_conv (
		.cmd (cmd_s1),
		.rsp (rsp_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// terms for the checks
	assign enc_on_grid  = valid_s1 && cmd_s1.opcode == OP_ENCODE && rsp_d.grid_flag_out;
	assign rsp_hi_clear = rsp.result_x[31:CODE_BITS] == '0 &&
		rsp.result_y[31:CODE_BITS] == '0 && rsp.result_z[31:CODE_BITS] == '0;

	// checks
	`GVQ_ASSERT_NEXT(a_accept_loads_stage, start && !busy, valid_s1)
	`GVQ_ASSERT_NEXT(a_stage_gives_word, valid_s1, done)
	`GVQ_ASSERT_NEXT(a_codes_narrow, enc_on_grid, rsp_hi_clear)

endmodule
